// ===== rtl/slas_pkg.sv =====
// Shared types and constants for the semi-Lagrangian advection sampler.
// Holds grid geometry, fixed-point widths, sequencer states and control word.
// No dependencies.
`default_nettype none

package slas_pkg;

    // Grid geometry.
    localparam int GRID_WIDTH  = 512;
    localparam int GRID_HEIGHT = 512;
    localparam int GRID_DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(GRID_DEPTH);
    localparam int XIDX_W      = $clog2(GRID_WIDTH);
    localparam int YIDX_W      = $clog2(GRID_HEIGHT);

    // Field widths.
    localparam int CELL_W = 9;
    localparam int DENS_W = 16;
    localparam int VEL_W  = 16;
    localparam int TS_W   = 16;

    // Fixed-point layout of the traced position.
    localparam int FRAC_W     = 8;
    localparam int DISP_SHIFT = 14;
    localparam int CALC_W     = 24;
    localparam int COORD_W    = CALC_W - FRAC_W;
    localparam int WGT_W      = FRAC_W + 1;
    localparam int COL_W      = DENS_W + FRAC_W;
    localparam int SUM_W      = DENS_W + 2 * FRAC_W;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = COL_W + 1;
    localparam int MUL_B_W = VEL_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [TS_W-1:0] TIME_STEP_RESET = TS_W'(1092);

    // Clamp range of the traced point: [-0.5, size - 0.5] in Q.8.
    localparam logic signed [CALC_W-1:0] POS_LO = CALC_W'(-(1 << (FRAC_W - 1)));
    localparam logic signed [CALC_W-1:0] POS_HI_X =
        CALC_W'(GRID_WIDTH * (1 << FRAC_W) - (1 << (FRAC_W - 1)));
    localparam logic signed [CALC_W-1:0] POS_HI_Y =
        CALC_W'(GRID_HEIGHT * (1 << FRAC_W) - (1 << (FRAC_W - 1)));
    localparam logic signed [COORD_W-1:0] X_LIMIT = COORD_W'(GRID_WIDTH);
    localparam logic signed [COORD_W-1:0] Y_LIMIT = COORD_W'(GRID_HEIGHT);

    // Request operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_TRACE,
        ST_RD00,
        ST_RD01,
        ST_RD10,
        ST_RD11,
        ST_MC0,
        ST_MC1,
        ST_MC2,
        ST_SUM,
        ST_DONE
    } slas_state_t;

    typedef enum logic [2:0] {
        MUL_VX,
        MUL_VY,
        MUL_T0,
        MUL_T1,
        MUL_S0,
        MUL_S1
    } slas_mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_COL0,
        ACC_COL1,
        ACC_SUM
    } slas_acc_dst_t;

    typedef struct packed {
        logic          s_ready;
        logic          out_ld;
        slas_mul_sel_t mul_sel;
        logic          rd_en;
        logic          nbr_dx;
        logic          nbr_dy;
        logic          ld_tx;
        logic          ld_ty;
        slas_acc_dst_t acc_dst;
        logic          acc_add;
    } slas_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/slas_ram.sv =====
// Generic single-port RAM with registered read data (read before write).
// Used for the density grid. No dependencies.
`default_nettype none

module slas_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/semi_lagrangian_advection_sampler_top.sv =====
// Top level of the semi-Lagrangian advection sampler: sequencer, shared
// multiplier datapath and output register. Depends on slas_pkg and slas_ram.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_valid / s_ready  operation, cell_x, cell_y, load_density,
//                                          velocity_x, velocity_y
//   m_*      out        m_valid / m_ready  out_x, out_y, advected_density
//   cfg_*    in         cfg_we             cfg_wdata (time_step)
//
// A load request is written into the grid memory at the edge that accepts
// it. A query request places its result in the output register once its
// steps are done, and the next request can be accepted in the cycle after
// that. The steps are two multiplies for the displacement, one clamp step,
// four grid reads through the single memory port that overlap the first
// three of six products on the shared multiplier, and the remaining products
// and sums.
// The sequence is set by that one multiplier and the one memory port.
// The output register holds a result until it is taken, and new requests are
// accepted meanwhile; a finished query waits in its last step only when the
// previous result has not yet been taken.
// Reset (aresetn low at a clock edge) returns the sequencer to idle, drops
// any pending result and restores time_step; the grid memory is not cleared.
`default_nettype none

module semi_lagrangian_advection_sampler_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [slas_pkg::TS_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [slas_pkg::CELL_W-1:0]       s_cell_x,
    input  logic [slas_pkg::CELL_W-1:0]       s_cell_y,
    input  logic [slas_pkg::DENS_W-1:0]       s_load_density,
    input  logic signed [slas_pkg::VEL_W-1:0] s_velocity_x,
    input  logic signed [slas_pkg::VEL_W-1:0] s_velocity_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [slas_pkg::CELL_W-1:0]       m_out_x,
    output logic [slas_pkg::CELL_W-1:0]       m_out_y,
    output logic [slas_pkg::DENS_W-1:0]       m_advected_density
);

    import slas_pkg::*;

    // Control state.
    slas_state_t state_reg, state_next;
    slas_ctrl_t  ctrl;
    logic [TS_W-1:0] ts_reg;
    logic            m_valid_reg;
    logic            out_free;

    // Request payload held for the duration of a query.
    logic [CELL_W-1:0]       cx_reg, cy_reg;
    logic signed [VEL_W-1:0] vx_reg, vy_reg;

    // Datapath registers.
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CALC_W-1:0] tx_reg, ty_reg;
    logic [COL_W-1:0]         col0_reg, col1_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic                     halo_reg;
    logic [CELL_W-1:0]        m_x_reg, m_y_reg;
    logic [DENS_W-1:0]        m_dens_reg;

    // Trace and clamp.
    logic signed [CALC_W-1:0] disp, base, pos_raw, pos_hi, pos_clamped;
    logic [CELL_W-1:0]        trace_cell;

    // Neighbor addressing.
    logic signed [COORD_W-1:0] x0, y0, nx, ny;
    logic                      halo_now;
    logic [ADDR_W-1:0]         rd_addr, ld_addr, ram_addr;
    logic                      load_wr, ram_en;
    logic [DENS_W-1:0]         ram_rdata, d_eff;

    // Weights and shared multiplier.
    logic [FRAC_W-1:0]         s1, t1;
    logic [WGT_W-1:0]          s0, t0;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    assign out_free = !m_valid_reg || m_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_operation == OP_QUERY) begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: state_next = ST_MUL_Y;
            ST_MUL_Y: state_next = ST_TRACE;
            ST_TRACE: state_next = ST_RD00;
            ST_RD00:  state_next = ST_RD01;
            ST_RD01:  state_next = ST_RD10;
            ST_RD10:  state_next = ST_RD11;
            ST_RD11:  state_next = ST_MC0;
            ST_MC0:   state_next = ST_MC1;
            ST_MC1:   state_next = ST_MC2;
            ST_MC2:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control word for each step. Reads are issued one step ahead of the
    // multiply that consumes them; each product is accumulated one step later.
    always_comb begin
        ctrl         = '0;
        ctrl.mul_sel = MUL_VX;
        ctrl.acc_dst = ACC_NONE;
        unique case (state_reg)
            ST_IDLE:  ctrl.s_ready = 1'b1;
            ST_MUL_X: ctrl.mul_sel = MUL_VX;
            ST_MUL_Y: begin
                ctrl.mul_sel = MUL_VY;
                ctrl.ld_tx   = 1'b1;
            end
            ST_TRACE: ctrl.ld_ty = 1'b1;
            ST_RD00:  ctrl.rd_en = 1'b1;
            ST_RD01: begin
                ctrl.rd_en   = 1'b1;
                ctrl.nbr_dy  = 1'b1;
                ctrl.mul_sel = MUL_T0;
            end
            ST_RD10: begin
                ctrl.rd_en   = 1'b1;
                ctrl.nbr_dx  = 1'b1;
                ctrl.mul_sel = MUL_T1;
                ctrl.acc_dst = ACC_COL0;
            end
            ST_RD11: begin
                ctrl.rd_en   = 1'b1;
                ctrl.nbr_dx  = 1'b1;
                ctrl.nbr_dy  = 1'b1;
                ctrl.mul_sel = MUL_T0;
                ctrl.acc_dst = ACC_COL0;
                ctrl.acc_add = 1'b1;
            end
            ST_MC0: begin
                ctrl.mul_sel = MUL_T1;
                ctrl.acc_dst = ACC_COL1;
            end
            ST_MC1: begin
                ctrl.mul_sel = MUL_S0;
                ctrl.acc_dst = ACC_COL1;
                ctrl.acc_add = 1'b1;
            end
            ST_MC2: begin
                ctrl.mul_sel = MUL_S1;
                ctrl.acc_dst = ACC_SUM;
            end
            ST_SUM: begin
                ctrl.acc_dst = ACC_SUM;
                ctrl.acc_add = 1'b1;
            end
            ST_DONE:  ctrl.out_ld = out_free;
            default:  ctrl.s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ts_reg      <= TIME_STEP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                ts_reg <= cfg_wdata;
            end
            if (ctrl.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the query payload at acceptance.
    always_ff @(posedge aclk) begin
        if (s_valid && ctrl.s_ready) begin
            cx_reg <= s_cell_x;
            cy_reg <= s_cell_y;
            vx_reg <= s_velocity_x;
            vy_reg <= s_velocity_y;
        end
    end

    // The displacement is the product floored to Q.8 by an arithmetic shift.
    // The traced point is cell * 256 minus that, clamped to the sampling range.
    assign disp       = prod_reg[DISP_SHIFT +: CALC_W];
    assign trace_cell = ctrl.ld_tx ? cx_reg : cy_reg;
    assign base       = signed'({{(CALC_W - CELL_W - FRAC_W){1'b0}}, trace_cell,
                                 {FRAC_W{1'b0}}});
    assign pos_raw    = base - disp;
    assign pos_hi     = ctrl.ld_tx ? POS_HI_X : POS_HI_Y;

    always_comb begin
        if (pos_raw < POS_LO) begin
            pos_clamped = POS_LO;
        end else if (pos_raw > pos_hi) begin
            pos_clamped = pos_hi;
        end else begin
            pos_clamped = pos_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_tx) begin
            tx_reg <= pos_clamped;
        end
        if (ctrl.ld_ty) begin
            ty_reg <= pos_clamped;
        end
    end

    // Neighbor cell and halo detection. The integer cell lies in [-1, size-1],
    // so the right or lower neighbor may fall one past the edge.
    assign x0 = tx_reg[CALC_W-1:FRAC_W];
    assign y0 = ty_reg[CALC_W-1:FRAC_W];
    assign nx = x0 + signed'(COORD_W'(ctrl.nbr_dx));
    assign ny = y0 + signed'(COORD_W'(ctrl.nbr_dy));
    assign halo_now = nx[COORD_W-1] || ny[COORD_W-1] || (nx >= X_LIMIT) ||
                      (ny >= Y_LIMIT);
    assign rd_addr = ADDR_W'(ny[YIDX_W-1:0]) * ADDR_W'(GRID_WIDTH) +
                     ADDR_W'(nx[XIDX_W-1:0]);

    // Loads outside the grid are dropped.
    assign ld_addr = ADDR_W'(s_cell_y) * ADDR_W'(GRID_WIDTH) + ADDR_W'(s_cell_x);
    assign load_wr = s_valid && ctrl.s_ready && (s_operation == OP_LOAD) &&
                     (COORD_W'(s_cell_x) < COORD_W'(GRID_WIDTH)) &&
                     (COORD_W'(s_cell_y) < COORD_W'(GRID_HEIGHT));
    assign ram_en   = load_wr || ctrl.rd_en;
    assign ram_addr = load_wr ? ld_addr : rd_addr;

    slas_ram #(
        .DEPTH (GRID_DEPTH),
        .WIDTH (DENS_W),
        .ADDR_W(ADDR_W)
    ) u_grid (
        .clk  (aclk),
        .en   (ram_en),
        .we   (load_wr),
        .addr (ram_addr),
        .wdata(s_load_density),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            halo_reg <= halo_now;
        end
    end

    assign d_eff = halo_reg ? '0 : ram_rdata;

    // Bilinear weights from the fractional bits.
    assign s1 = tx_reg[FRAC_W-1:0];
    assign t1 = ty_reg[FRAC_W-1:0];
    assign s0 = WGT_W'(1 << FRAC_W) - WGT_W'(s1);
    assign t0 = WGT_W'(1 << FRAC_W) - WGT_W'(t1);

    // Shared multiplier operand selection.
    always_comb begin
        case (ctrl.mul_sel)
            MUL_VX: begin
                mul_a = MUL_A_W'(ts_reg);
                mul_b = MUL_B_W'(vx_reg);
            end
            MUL_VY: begin
                mul_a = MUL_A_W'(ts_reg);
                mul_b = MUL_B_W'(vy_reg);
            end
            MUL_T0: begin
                mul_a = MUL_A_W'(d_eff);
                mul_b = MUL_B_W'(t0);
            end
            MUL_T1: begin
                mul_a = MUL_A_W'(d_eff);
                mul_b = MUL_B_W'(t1);
            end
            MUL_S0: begin
                mul_a = MUL_A_W'(col0_reg);
                mul_b = MUL_B_W'(s0);
            end
            MUL_S1: begin
                mul_a = MUL_A_W'(col1_reg);
                mul_b = MUL_B_W'(s1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Accumulation of column sums and the final blend.
    always_ff @(posedge aclk) begin
        case (ctrl.acc_dst)
            ACC_COL0: begin
                col0_reg <= ctrl.acc_add ? col0_reg + prod_reg[COL_W-1:0]
                                         : prod_reg[COL_W-1:0];
            end
            ACC_COL1: begin
                col1_reg <= ctrl.acc_add ? col1_reg + prod_reg[COL_W-1:0]
                                         : prod_reg[COL_W-1:0];
            end
            ACC_SUM: begin
                sum_reg <= ctrl.acc_add ? sum_reg + prod_reg[SUM_W-1:0]
                                        : prod_reg[SUM_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Output register: the blend truncated by 16 fractional bits.
    always_ff @(posedge aclk) begin
        if (ctrl.out_ld) begin
            m_x_reg    <= cx_reg;
            m_y_reg    <= cy_reg;
            m_dens_reg <= sum_reg[SUM_W-1 -: DENS_W];
        end
    end

    assign s_ready            = ctrl.s_ready;
    assign m_valid            = m_valid_reg;
    assign m_out_x            = m_x_reg;
    assign m_out_y            = m_y_reg;
    assign m_advected_density = m_dens_reg;

endmodule

`default_nettype wire

// ===== rtl/slas_checker.sv =====
// Port-level checker for the advection sampler top level, with its bind.
// Depends only on the top level's ports.
`default_nettype none

module slas_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_operation,
    input logic        m_valid,
    input logic        m_ready,
    input logic [8:0]  m_out_x,
    input logic [8:0]  m_out_y,
    input logic [15:0] m_advected_density
);

    // Reset drops any pending result.
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A query keeps the block busy for the following cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation) |=> !s_ready)
        else $error("request accepted right after a query");

    // A load completes at once and leaves the block ready.
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_operation) |=> s_ready)
        else $error("not ready after a load");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_x) &&
            $stable(m_out_y) && $stable(m_advected_density)))
        else $error("stalled result changed");

endmodule

bind semi_lagrangian_advection_sampler_top slas_checker u_slas_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_operation       (s_operation),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_out_x           (m_out_x),
    .m_out_y           (m_out_y),
    .m_advected_density(m_advected_density)
);

`default_nettype wire
